/* rtl/core/sfm_pkg.sv */
// shared constants and types of the saturating pcm frame mixer
`default_nettype none
package sfm_pkg;

	localparam int MAX_FRAME_SAMPLES = 2048;
	localparam int MAX_SOURCES       = 16;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 12;
	localparam int ADDR_W   = (MAX_FRAME_SAMPLES > 1) ? $clog2(MAX_FRAME_SAMPLES) : 1;
	localparam int LEN_W    = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int CNT_W    = $clog2(MAX_SOURCES + 1);
	localparam int DIV_W    = $clog2(MAX_SOURCES / 2 + 1);
	localparam int STEP_W   = $clog2(SAMPLE_W);

	localparam logic [CFG_W-1:0] FRAME_LEN_RESET = CFG_W'(1920);

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} op_t;

endpackage
`default_nettype wire

/* rtl/core/saturating_pcm_frame_mixer_unit.sv */
// top level of the saturating pcm frame mixer
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  in       | in_valid / in_ready  | op, sample
//  out      | out_valid / out_ready| mixed_sample, last, empty_res
//  cfg      | cfg_we (no wait)     | cfg_wdata (samples_in_frame)
//
//  an add request for the first source writes the store directly; a later
//  source takes a store read, then clamp and write back. a read request takes
//  a store read and, with attenuation, the 16-step restoring divider.
//  one request is in work at a time; the output register holds a result
//  while the next request is taken. reset needs no clearing pass: store
//  entries are undefined until written.
`default_nettype none
module saturating_pcm_frame_mixer_unit
	import sfm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       op,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      mixed_sample,
	output logic                            last,
	output logic                            empty_res,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_W-1:0]           cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WB,
		ST_RD_WAIT,
		ST_DIV,
		ST_DIV_END,
		ST_OUT
	} state_t;

	state_t                      state_q;
	logic [CFG_W-1:0]            frame_cfg_q;
	logic [ADDR_W-1:0]           add_pos_q;
	logic [ADDR_W-1:0]           read_pos_q;
	logic [CNT_W-1:0]            src_cnt_q;
	logic                        reading_q;
	logic [ADDR_W-1:0]           pos_q;
	logic                        wrap_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic signed [SAMPLE_W-1:0]  res_q;
	logic                        res_last_q;
	logic                        res_empty_q;
	logic [SAMPLE_W-1:0]         quo_q;
	logic [DIV_W-1:0]            rem_q;
	logic [DIV_W-1:0]            divisor_q;
	logic                        neg_q;
	logic [STEP_W-1:0]           step_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  out_sample_q;
	logic                        out_last_q;
	logic                        out_empty_q;

	logic [LEN_W-1:0]            frame_len;
	logic                        accept;
	logic [CNT_W-1:0]            cnt_eff;
	logic [ADDR_W-1:0]           apos_eff;
	logic [ADDR_W-1:0]           rpos_eff;
	logic [ADDR_W-1:0]           cur_pos;
	logic [LEN_W-1:0]            pos_next;
	logic                        pos_wrap;
	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_addr;
	logic [SAMPLE_W-1:0]         ram_wdata;
	logic [SAMPLE_W-1:0]         ram_rdata;
	logic signed [SAMPLE_W:0]    sum;
	logic signed [SAMPLE_W-1:0]  sum_clamped;
	logic [DIV_W:0]              trial;
	logic                        trial_ge;
	logic [SAMPLE_W-1:0]         rd_mag;
	logic                        out_free;

	sfm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_FRAME_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign mixed_sample = out_sample_q;
	assign last         = out_last_q;
	assign empty_res    = out_empty_q;
	assign out_free     = !out_valid_q || out_ready;

	always_comb begin
		if (frame_cfg_q == '0) begin
			frame_len = LEN_W'(1);
		end else if (32'(frame_cfg_q) > MAX_FRAME_SAMPLES) begin
			frame_len = LEN_W'(MAX_FRAME_SAMPLES);
		end else begin
			frame_len = LEN_W'(frame_cfg_q);
		end
	end

	always_comb begin
		cnt_eff  = reading_q ? '0 : src_cnt_q;
		apos_eff = reading_q ? '0 : add_pos_q;
		rpos_eff = reading_q ? read_pos_q : '0;
		if (op == OP_ADD) begin
			cur_pos = (LEN_W'(apos_eff) >= frame_len) ? '0 : apos_eff;
		end else begin
			cur_pos = (LEN_W'(rpos_eff) >= frame_len) ? '0 : rpos_eff;
		end
		pos_next = LEN_W'(cur_pos) + LEN_W'(1);
		pos_wrap = (pos_next >= frame_len);
	end

	always_comb begin
		sum = {ram_rdata[SAMPLE_W-1], ram_rdata} + {sample_q[SAMPLE_W-1], sample_q};
		priority if (sum > (SAMPLE_W+1)'(SMP_MAX)) begin
			sum_clamped = SMP_MAX;
		end else if (sum < (SAMPLE_W+1)'(SMP_MIN)) begin
			sum_clamped = SMP_MIN;
		end else begin
			sum_clamped = sum[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		trial    = {rem_q, quo_q[SAMPLE_W-1]};
		trial_ge = (trial >= {1'b0, divisor_q});
		rd_mag   = ram_rdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - ram_rdata) : ram_rdata;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pos_q;
		ram_wdata = sum_clamped;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr  = cur_pos;
				ram_wdata = sample;
				ram_we    = accept && (op == OP_ADD) && (cnt_eff == '0);
			end
			ST_ADD_WB: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_cfg_q <= FRAME_LEN_RESET;
			add_pos_q   <= '0;
			read_pos_q  <= '0;
			src_cnt_q   <= '0;
			reading_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_cfg_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q    <= cur_pos;
						wrap_q   <= pos_wrap;
						sample_q <= sample;
						if (op == OP_ADD) begin
							reading_q <= 1'b0;
							if (reading_q) begin
								read_pos_q <= '0;
							end
							if (cnt_eff == '0) begin
								add_pos_q <= pos_wrap ? '0 : ADDR_W'(pos_next);
								src_cnt_q <= pos_wrap ? CNT_W'(1) : cnt_eff;
							end else begin
								src_cnt_q <= cnt_eff;
								add_pos_q <= apos_eff;
								if (32'(cnt_eff) < MAX_SOURCES) begin
									state_q <= ST_ADD_WB;
								end
							end
						end else begin
							reading_q <= 1'b1;
							if (!reading_q) begin
								add_pos_q <= '0;
							end
							if (src_cnt_q == '0) begin
								res_q       <= '0;
								res_last_q  <= 1'b0;
								res_empty_q <= 1'b1;
								read_pos_q  <= rpos_eff;
								state_q     <= ST_OUT;
							end else begin
								res_last_q  <= pos_wrap;
								res_empty_q <= 1'b0;
								read_pos_q  <= pos_wrap ? '0 : ADDR_W'(pos_next);
								state_q     <= ST_RD_WAIT;
							end
						end
					end
				end
				ST_ADD_WB: begin
					add_pos_q <= wrap_q ? '0 : ADDR_W'(LEN_W'(pos_q) + LEN_W'(1));
					if (wrap_q) begin
						src_cnt_q <= src_cnt_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_RD_WAIT: begin
					if (src_cnt_q > CNT_W'(2)) begin
						divisor_q <= DIV_W'(src_cnt_q >> 1);
						neg_q     <= ram_rdata[SAMPLE_W-1];
						quo_q     <= rd_mag;
						rem_q     <= '0;
						step_q    <= STEP_W'(SAMPLE_W - 1);
						state_q   <= ST_DIV;
					end else begin
						res_q   <= ram_rdata;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (trial_ge) begin
						rem_q <= DIV_W'(trial - {1'b0, divisor_q});
					end else begin
						rem_q <= trial[DIV_W-1:0];
					end
					quo_q <= {quo_q[SAMPLE_W-2:0], trial_ge};
					if (step_q == '0) begin
						state_q <= ST_DIV_END;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DIV_END: begin
					res_q   <= neg_q ? (SAMPLE_W'(0) - quo_q) : quo_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= res_q;
						out_last_q   <= res_last_q;
						out_empty_q  <= res_empty_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sfm_ram.sv */
// generic single port ram with registered read
`default_nettype none
module sfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                           wdata,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* rtl/core/sfm_checker.sv */
// port level checks of the saturating pcm frame mixer, bound to the top level
`default_nettype none
module sfm_checker
	import sfm_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       op,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [SAMPLE_W-1:0] mixed_sample,
	input wire logic                       last,
	input wire logic                       empty_res
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mixed_sample) && $stable(last)
			&& $stable(empty_res))
		else $error("output changed while stalled");

	// an empty result carries no sample and no frame end
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> mixed_sample == '0 && !last)
		else $error("empty result with data");

	// no result appears in the cycle right after a request is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// a read request keeps the input closed in the next cycle
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_READ |=> !in_ready)
		else $error("read request overlapped with next request");

endmodule

bind saturating_pcm_frame_mixer_unit sfm_checker u_sfm_checker (.*);
`default_nettype wire

/* dv/saturating_pcm_frame_mixer_unit_test.sv */
// testbench of the saturating pcm frame mixer: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module saturating_pcm_frame_mixer_unit_test
	import sfm_pkg::*;
();

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       last;
		logic                       empty;
	} mix_result_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	op_t                        op        = OP_ADD;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       last;
	logic                       empty_res;
	logic                       cfg_we    = 1'b0;
	logic [CFG_W-1:0]           cfg_wdata = '0;

	// predictor state
	logic signed [SAMPLE_W-1:0] mix_mem [MAX_FRAME_SAMPLES];
	logic [10:0]                add_pos     = '0;
	logic [10:0]                rd_pos      = '0;
	logic [4:0]                 src_cnt     = '0;
	logic                       reading     = 1'b0;
	logic [CFG_W-1:0]           frame_cfg   = FRAME_LEN_RESET;

	mix_result_t expected_mix [$];

	int src_idle_pct  = 27;
	int sink_idle_pct = 27;
	int mismatches    = 0;
	int n_adds        = 0;
	int n_reads       = 0;
	int n_results     = 0;
	int cfg_writes    = 0;
	int max_mixed     = 0;

	saturating_pcm_frame_mixer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_sample (mixed_sample),
		.last         (last),
		.empty_res    (empty_res),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic void predict_request(op_t kind, logic signed [SAMPLE_W-1:0] smp);
		int len;
		int pos;
		int v;
		mix_result_t r;
		len = (frame_cfg == '0) ? 1 :
			((frame_cfg > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES : int'(frame_cfg));
		if (kind == OP_ADD) begin
			// first add after reading starts a new mix
			if (reading) begin
				reading = 1'b0;
				src_cnt = '0;
				add_pos = '0;
				rd_pos  = '0;
			end
			if (src_cnt >= MAX_SOURCES)
				return;
			pos = int'(add_pos);
			if (pos >= len)
				pos = 0;
			if (src_cnt == '0) begin
				v = int'(smp);
			end else begin
				v = int'(mix_mem[pos]) + int'(smp);
				if (v > int'(SMP_MAX))
					v = int'(SMP_MAX);
				if (v < int'(SMP_MIN))
					v = int'(SMP_MIN);
			end
			mix_mem[pos] = v[SAMPLE_W-1:0];
			pos++;
			if (pos >= len) begin
				add_pos = '0;
				src_cnt = src_cnt + 1'b1;
			end else begin
				add_pos = pos[10:0];
			end
			return;
		end
		if (!reading) begin
			reading = 1'b1;
			rd_pos  = '0;
			add_pos = '0;
		end
		if (src_cnt == '0) begin
			r.smp   = '0;
			r.last  = 1'b0;
			r.empty = 1'b1;
			expected_mix.insert(expected_mix.size(), r);
			return;
		end
		if (int'(src_cnt) > max_mixed)
			max_mixed = int'(src_cnt);
		pos = int'(rd_pos);
		if (pos >= len)
			pos = 0;
		v = int'(mix_mem[pos]);
		if (src_cnt > 5'd2)
			v = v / int'(src_cnt / 5'd2);
		r.smp   = v[SAMPLE_W-1:0];
		r.empty = 1'b0;
		if (pos + 1 >= len) begin
			r.last = 1'b1;
			rd_pos = '0;
		end else begin
			r.last = 1'b0;
			rd_pos = 11'(pos + 1);
		end
		expected_mix.insert(expected_mix.size(), r);
	endfunction

	task automatic report_mismatch(string field, logic signed [SAMPLE_W-1:0] exp_v,
		logic signed [SAMPLE_W-1:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, exp_v, act_v);
	endtask

	always @(posedge clk) begin : check_results
		mix_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_mix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none expected, mixed_sample %0d",
						$realtime, mixed_sample);
			end else begin
				want = expected_mix.pop_front();
				if (mixed_sample !== want.smp)
					report_mismatch("mixed_sample", want.smp, mixed_sample);
				if (last !== want.last)
					report_mismatch("last", want.last, last);
				if (empty_res !== want.empty)
					report_mismatch("empty_res", want.empty, empty_res);
			end
		end
	end

	task automatic send_request(op_t kind, logic signed [SAMPLE_W-1:0] smp);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op       = kind;
		sample   = (kind == OP_ADD) ? smp : SAMPLE_W'($urandom_range(0, 65535));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_request(kind, sample);
		if (kind == OP_ADD)
			n_adds++;
		else
			n_reads++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_mix.size() != 0)
			@(negedge clk);
		// an add may still be in work
		repeat (32) @(negedge clk);
	endtask

	task automatic set_frame_length(logic [CFG_W-1:0] v);
		wait_drained();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		frame_cfg = v;
		cfg_writes++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return SAMPLE_W'($urandom_range(0, 15) - 8);
			default: return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic test_empty_reads();
		send_request(OP_READ, '0);
		send_request(OP_READ, '0);
		send_request(OP_ADD, SMP_MAX);
		send_request(OP_ADD, SMP_MIN);
		send_request(OP_ADD, 16'sh5555);
		send_request(OP_READ, '0);
		send_request(OP_READ, '0);
	endtask

	task automatic test_clamp_and_sources();
		int i;
		set_frame_length('0);
		send_request(OP_ADD, SMP_MAX);
		send_request(OP_ADD, SMP_MAX);
		send_request(OP_READ, '0);
		send_request(OP_READ, '0);
		send_request(OP_ADD, SMP_MIN);
		send_request(OP_ADD, SMP_MIN);
		send_request(OP_ADD, SMP_MIN);
		send_request(OP_READ, '0);
		set_frame_length(12'd1);
		// negative sum over eight must truncate toward zero, extra sources ignored
		send_request(OP_ADD, -16'sd7);
		for (i = 1; i < MAX_SOURCES; i++)
			send_request(OP_ADD, '0);
		send_request(OP_ADD, SMP_MAX);
		send_request(OP_ADD, SMP_MAX);
		send_request(OP_READ, '0);
	endtask

	task automatic test_shrink_frame();
		int i;
		set_frame_length(12'd8);
		for (i = 0; i < 13; i++)
			send_request(OP_ADD, pick_sample());
		set_frame_length(12'd3);
		for (i = 0; i < 3; i++)
			send_request(OP_ADD, pick_sample());
		send_request(OP_READ, '0);
		send_request(OP_READ, '0);
		set_frame_length(12'd2);
		for (i = 0; i < 3; i++)
			send_request(OP_READ, '0);
	endtask

	task automatic test_largest_frame();
		int i;
		// an oversized length leaves this source incomplete
		set_frame_length(12'hfff);
		for (i = 0; i < 24; i++)
			send_request(OP_ADD, pick_sample());
		send_request(OP_READ, '0);
		send_request(OP_READ, '0);
	endtask

	task automatic test_random_mixes();
		int mix_no;
		int len;
		int sources;
		int partial;
		int i;
		int j;
		mix_no = 0;
		while (n_adds + n_reads < 1800) begin
			src_idle_pct  = (mix_no >= 8 && mix_no < 20) ? 0 : 27;
			sink_idle_pct = src_idle_pct;
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: sources = $urandom_range(1, 4);
				6, 7:             sources = $urandom_range(5, 12);
				8:                sources = $urandom_range(13, 18);
				default:          sources = 0;
			endcase
			len = ($urandom_range(3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			partial = (len > 1 && $urandom_range(3) == 0) ? $urandom_range(1, len - 1) : 0;
			// a mix that opens with reads keeps the old frame length
			if (sources > 0 || partial > 0)
				set_frame_length((len == 1 && $urandom_range(1) == 0) ? '0 : CFG_W'(len));
			for (i = 0; i < sources; i++) begin
				for (j = 0; j < len; j++) begin
					if ($urandom_range(59) == 0)
						send_request(OP_READ, '0);
					send_request(OP_ADD, pick_sample());
				end
			end
			for (j = 0; j < partial; j++)
				send_request(OP_ADD, pick_sample());
			j = $urandom_range(1, 2 * len + 1);
			for (i = 0; i < j; i++)
				send_request(OP_READ, '0);
			mix_no++;
		end
		src_idle_pct  = 27;
		sink_idle_pct = 27;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_empty_reads();
		test_clamp_and_sources();
		test_shrink_frame();
		test_largest_frame();
		test_random_mixes();
		wait_drained();
		$display("sent %0d requests (%0d adds, %0d reads), checked %0d results",
			n_adds + n_reads, n_adds, n_reads, n_results);
		$display("%0d frame length writes, up to %0d sources in one mix", cfg_writes, max_mixed);
		if (mismatches == 0 && expected_mix.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results outstanding", expected_mix.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sfm_pkg.sv
rtl/core/sfm_ram.sv
rtl/core/saturating_pcm_frame_mixer_unit.sv
rtl/core/sfm_checker.sv
dv/saturating_pcm_frame_mixer_unit_test.sv
